FILE: rtl/core/atok_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atok_pkg
// shared types, codes and character constants of the expression tokeniser
// ----------------------------------------------------------------------------
package atok_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int TOK_W        = 16;
  localparam int MAX_RES      = 3;
  localparam int CNT_W        = 2;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_INT  = 2'd1,
    MODE_FRAC = 2'd2,
    MODE_ID   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    KIND_END     = 4'd0,
    KIND_NUMBER  = 4'd1,
    KIND_IDENT   = 4'd2,
    KIND_PLUS    = 4'd3,
    KIND_MINUS   = 4'd4,
    KIND_STAR    = 4'd5,
    KIND_SLASH   = 4'd6,
    KIND_LPAREN  = 4'd7,
    KIND_RPAREN  = 4'd8,
    KIND_DOLLAR  = 4'd9,
    KIND_EQUAL   = 4'd10,
    KIND_INVALID = 4'd11
  } kind_t;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;

  typedef struct packed {
    kind_t              kind;
    logic [TOK_W-1:0]   start;
    logic [TOK_W-1:0]   length;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_RES-1:0] items;
    logic [CNT_W-1:0]   count;
  } tok_batch_t;

  function automatic kind_t op_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_DOLLAR: k = KIND_DOLLAR;
      CH_EQUAL:  k = KIND_EQUAL;
      default:   k = KIND_INVALID;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/atok_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atok_scan
// scan state and per-character classification, builds up to three tokens
// ----------------------------------------------------------------------------
module atok_scan
  import atok_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] char_code,
  input  wire logic       last_char,
  output tok_batch_t      batch
);

  localparam int EXT_W = (POS_BITS > TOK_W) ? POS_BITS : TOK_W;

  mode_t               mode_r, mode_nxt, mode_mid;
  logic [POS_BITS-1:0] begin_r, begin_nxt, begin_mid;
  logic [POS_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic                char_digit, char_alpha, is_dot, char_space, consumed;
  tok_t [MAX_RES-1:0]  cand;
  logic [MAX_RES-1:0]  cand_vld;
  logic [CNT_W-1:0]    n;

  function automatic logic [TOK_W-1:0] pos16(input logic [POS_BITS-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[TOK_W-1:0];
  endfunction

  always_comb begin
    char_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    char_alpha = (char_code == CH_USCORE) ||
                 ((char_code >= CH_LOW_A) && (char_code <= CH_LOW_Z)) ||
                 ((char_code >= CH_UP_A) && (char_code <= CH_UP_Z));
    is_dot     = (char_code == CH_DOT);
    char_space = (char_code == CH_SPACE);
    pos_inc    = (pos_r == '1) ? pos_r : pos_r + POS_BITS'(1);
  end

  always_comb begin
    cand     = '0;
    cand_vld = '0;
    consumed = 1'b0;
    mode_mid = mode_r;
    begin_mid = begin_r;

    case (mode_r)
      MODE_INT:  consumed = char_digit || is_dot;
      MODE_FRAC: consumed = char_digit;
      MODE_ID:   consumed = char_digit || char_alpha;
      default:   consumed = 1'b0;
    endcase
    if (mode_r == MODE_INT && is_dot) begin
      mode_mid = MODE_FRAC;
    end

    // pending token closed by this character
    if (!consumed && mode_r != MODE_IDLE) begin
      cand_vld[0]    = 1'b1;
      cand[0].kind   = (mode_r == MODE_ID) ? KIND_IDENT : KIND_NUMBER;
      cand[0].start  = pos16(begin_r);
      cand[0].length = pos16(pos_r - begin_r);
      mode_mid       = MODE_IDLE;
    end

    if (!consumed) begin
      if (char_space) begin
        mode_mid = MODE_IDLE;
      end else if (char_alpha) begin
        mode_mid  = MODE_ID;
        begin_mid = pos_r;
      end else if (char_digit) begin
        mode_mid  = MODE_INT;
        begin_mid = pos_r;
      end else begin
        cand_vld[1]    = 1'b1;
        cand[1].kind   = op_kind(char_code);
        cand[1].start  = pos16(pos_r);
        cand[1].length = TOK_W'(1);
      end
    end

    // flush and end marker on the final character
    if (last_char) begin
      if (mode_mid != MODE_IDLE) begin
        cand_vld[1]    = 1'b1;
        cand[1].kind   = (mode_mid == MODE_ID) ? KIND_IDENT : KIND_NUMBER;
        cand[1].start  = pos16(begin_mid);
        cand[1].length = pos16(pos_inc - begin_mid);
      end
      cand_vld[2]    = 1'b1;
      cand[2].kind   = KIND_END;
      cand[2].start  = pos16(pos_inc);
      cand[2].length = '0;
      mode_nxt       = MODE_IDLE;
      begin_nxt      = '0;
      pos_nxt        = '0;
    end else begin
      mode_nxt  = mode_mid;
      begin_nxt = begin_mid;
      pos_nxt   = pos_inc;
    end
  end

  // pack valid candidates to the front in order
  always_comb begin
    batch.items = '0;
    n = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      if (cand_vld[i]) begin
        batch.items[n] = cand[i];
        n = n + CNT_W'(1);
      end
    end
    batch.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      begin_r <= '0;
      pos_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
    end
  end

  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_char |=> pos_r == '0 && mode_r == MODE_IDLE && begin_r == '0)
    else $error("state not rewound after final character");

  a_no_frac_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode_r == MODE_IDLE |=> mode_r != MODE_FRAC)
    else $error("fraction mode entered without an integer part");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !last_char && pos_r == '1 |=> pos_r == '1)
    else $error("position wrapped past saturation");

endmodule
`default_nettype wire

FILE: rtl/core/atok_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atok_outbuf
// three-slot buffer takes whole batches, drains one a cycle while out_ready
// ----------------------------------------------------------------------------
module atok_outbuf
  import atok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire tok_batch_t batch,
  output logic            can_load,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tok_t            out_tok,
  output logic            out_last
);

  tok_t [MAX_RES-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);
  assign out_tok   = q_r[0];
  // it refills only when empty or popping its last entry, which ends its batch
  assign out_last  = (cnt_r == CNT_W'(1));

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (load) begin
      q_nxt   = batch.items;
      cnt_nxt = batch.count;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> cnt_r == '0 || (cnt_r == CNT_W'(1) && pop))
    else $error("batch loaded over undelivered results");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result count beyond buffer depth");

  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(q_r[0]) && $stable(cnt_r))
    else $error("head result changed while stalled");

endmodule
`default_nettype wire

FILE: rtl/core/arith_expression_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arith_expression_tokenizer
// streaming lexer for arithmetic expressions, one character per transfer
// ----------------------------------------------------------------------------
// Characters arrive one per input transfer, with in_last_char marking the
// final character of an expression. The block scans numbers (digits with an
// optional dot and fraction, a trailing dot belonging to the number),
// identifiers (letter or underscore, then letters, digits, underscores), the
// operators + - * / ( ) $ = and flags any character but a space as invalid.
// A number or identifier is reported when the character after it ends it; on
// the final character any pending token is flushed and an end token (length
// zero, start just past the last character) follows, and the scan rewinds to
// position zero. Positions saturate at 2^POS_BITS-1 and are reported in their
// low 16 bits. Each character produces zero to three result transfers, the
// last of which carries out_last_result. A character is taken every cycle as
// long as the results of the previous one fit: the three-slot result buffer
// accepts a new batch when it is empty or delivering its final entry, so a
// character giving at most one token streams at one per cycle while
// out_ready is high; one giving more stalls input until its tokens drain.
// ----------------------------------------------------------------------------
module arith_expression_tokenizer
  import atok_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // character input
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_char_code,
  input  wire logic             in_last_char,
  // token output
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [3:0]            out_token_kind,
  output logic [TOK_W-1:0]      out_token_start,
  output logic [TOK_W-1:0]      out_token_length,
  output logic                  out_last_result
);

  logic       accept;
  tok_batch_t batch;
  tok_t       head;

  // an input transfer updates the scan state and loads its tokens at once
  assign accept = in_valid && in_ready;

  atok_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .batch     (batch)
  );

  // result buffer parts the output handshake from the scan
  atok_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .batch     (batch),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (head),
    .out_last  (out_last_result)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;

endmodule
`default_nettype wire
